[hw/rtl/titration_cycle_sequencer_unit_macros.svh]
// Assertion macros shared by the titration cycle sequencer RTL.
`ifndef TITRATION_CYCLE_SEQUENCER_UNIT_MACROS_SVH
`define TITRATION_CYCLE_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define TCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcs: same-cycle check failed");
// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define TCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcs: next-cycle check failed");
`else
`define TCS_ASSERT_NOW(label, ante, cons)
`define TCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/tcs_pkg.sv]
// Types and constants of the titration cycle sequencer.
`default_nettype none

package tcs_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PH_W     = 11;
    localparam int unsigned TEMP_W   = 15;
    localparam int unsigned ERR_W    = 4;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_POLL  = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_DRAIN     = 3'd1,
        PH_REF_FILL  = 3'd2,
        PH_COLLECT   = 3'd3,
        PH_MEASURE   = 3'd4,
        PH_EMPTY     = 3'd5,
        PH_COMPLETE  = 3'd6,
        PH_ERROR     = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        SUB_IDLE  = 3'd0,
        SUB_ONE   = 3'd1,
        SUB_TWO   = 3'd2,
        SUB_THREE = 3'd3
    } sub_t;

    localparam logic [ERR_W-1:0] ERR_NONE          = 4'd0;
    localparam logic [ERR_W-1:0] ERR_UNCONFIGURED  = 4'd1;
    localparam logic [ERR_W-1:0] ERR_BUSY          = 4'd2;
    localparam logic [ERR_W-1:0] ERR_DRAIN_START   = 4'd3;
    localparam logic [ERR_W-1:0] ERR_DRAIN_RUN     = 4'd4;
    localparam logic [ERR_W-1:0] ERR_FILL_START    = 4'd5;
    localparam logic [ERR_W-1:0] ERR_FILL_RUN      = 4'd6;
    localparam logic [ERR_W-1:0] ERR_COLLECT_START = 4'd7;
    localparam logic [ERR_W-1:0] ERR_COLLECT_RUN   = 4'd8;
    localparam logic [ERR_W-1:0] ERR_KH_RANGE      = 4'd9;
    localparam logic [ERR_W-1:0] ERR_PH_DELTA      = 4'd10;

    localparam logic [1:0] PUMP_A_OFF   = 2'd0;
    localparam logic [1:0] PUMP_A_FILL  = 2'd1;
    localparam logic [1:0] PUMP_A_DRAIN = 2'd2;
    localparam logic       PUMP_B_OFF   = 1'b0;
    localparam logic       PUMP_B_XFER  = 1'b1;
    localparam logic [1:0] PUMP_C_OFF   = 2'd0;
    localparam logic [1:0] PUMP_C_FILL  = 2'd1;
    localparam logic [1:0] PUMP_C_XFER  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_SET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_FIRST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_THIRD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLLECT       = 3'd5;

    // KH in hundredths of dKH is fifty times the pH drop in hundredths.
    localparam logic signed [17:0] KH_SCALE  = 18'sd50;
    localparam logic signed [17:0] KH_MIN    = 18'sd100;
    localparam logic signed [17:0] KH_MAX    = 18'sd2000;
    localparam logic [PH_W-1:0]    DELTA_MIN = 11'd10;
    localparam logic [PH_W-1:0]    DELTA_MAX = 11'd400;

    typedef struct packed {
        logic              reference_set;
        logic [TIME_W-1:0] drain_second_ms;
        logic [TIME_W-1:0] drain_first_ms;
        logic [TIME_W-1:0] fill_third_ms;
        logic [TIME_W-1:0] settle_ms;
        logic [TIME_W-1:0] collect_ms;
    } cfg_t;

    typedef struct packed {
        req_type_t                req_type;
        logic [TIME_W-1:0]        now_ms;
        logic                     first_full;
        logic                     second_full;
        logic                     third_full;
        logic [PH_W-1:0]          ph_reading;
        logic signed [TEMP_W-1:0] temp_reading;
    } req_t;

    typedef struct packed {
        logic [2:0]               cycle_state;
        logic                     advanced;
        logic [ERR_W-1:0]         error_code;
        logic [1:0]               pump_first_cmd;
        logic                     pump_second_cmd;
        logic [1:0]               pump_third_cmd;
        logic [PH_W-1:0]          kh_centi;
        logic                     result_valid;
        logic [PH_W-1:0]          ph_ref_out;
        logic [PH_W-1:0]          ph_sample_out;
        logic signed [TEMP_W-1:0] temp_out;
    } res_t;

    typedef struct packed {
        logic [PH_W-1:0]  kh;
        logic [ERR_W-1:0] err;
        logic             ok;
    } kh_res_t;

    // Actions decided by the phase logic for one request.
    typedef struct packed {
        logic             adv;
        logic             err_wr;
        logic [ERR_W-1:0] err_val;
        logic             pa_wr;
        logic [1:0]       pa_val;
        logic             pb_wr;
        logic             pb_val;
        logic             pc_wr;
        logic [1:0]       pc_val;
        logic             time_wr;
        logic             ref_wr;
        logic             meas_wr;
        logic             res_clear;
        logic             pumps_clear;
    } seq_act_t;

endpackage

`default_nettype wire

[hw/rtl/tcs_if.sv]
// Request, result and configuration channel interfaces of the sequencer.
`default_nettype none

interface tcs_req_if;
    logic                                      valid;
    logic                                      ready;
    logic [1:0]                                req_type;
    logic [tcs_pkg::TIME_W-1:0]                now_ms;
    logic                                      first_full;
    logic                                      second_full;
    logic                                      third_full;
    logic [tcs_pkg::PH_W-1:0]                  ph_reading;
    logic signed [tcs_pkg::TEMP_W-1:0]         temp_reading;

    modport source (output valid, req_type, now_ms, first_full, second_full,
                    third_full, ph_reading, temp_reading, input ready);
    modport sink (input valid, req_type, now_ms, first_full, second_full,
                  third_full, ph_reading, temp_reading, output ready);
endinterface

interface tcs_res_if;
    logic                                      valid;
    logic                                      ready;
    logic [2:0]                                cycle_state;
    logic                                      advanced;
    logic [tcs_pkg::ERR_W-1:0]                 error_code;
    logic [1:0]                                pump_first_cmd;
    logic                                      pump_second_cmd;
    logic [1:0]                                pump_third_cmd;
    logic [tcs_pkg::PH_W-1:0]                  kh_centi;
    logic                                      result_valid;
    logic [tcs_pkg::PH_W-1:0]                  ph_ref_out;
    logic [tcs_pkg::PH_W-1:0]                  ph_sample_out;
    logic signed [tcs_pkg::TEMP_W-1:0]         temp_out;

    modport source (output valid, cycle_state, advanced, error_code, pump_first_cmd,
                    pump_second_cmd, pump_third_cmd, kh_centi, result_valid,
                    ph_ref_out, ph_sample_out, temp_out, input ready);
    modport sink (input valid, cycle_state, advanced, error_code, pump_first_cmd,
                  pump_second_cmd, pump_third_cmd, kh_centi, result_valid,
                  ph_ref_out, ph_sample_out, temp_out, output ready);
endinterface

interface tcs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tcs_pkg::CFG_IDX_W-1:0]     index;
    logic [tcs_pkg::TIME_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/tcs_cfg_regs.sv]
// Configuration register file of the titration cycle sequencer.
`default_nettype none

module tcs_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tcs_cfg_if.sink      cfg,
    output tcs_pkg::cfg_t cfg_q
);

    tcs_pkg::cfg_t cfg_reg;
    tcs_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                tcs_pkg::CFG_REFERENCE_SET: cfg_next.reference_set   = cfg.data[0];
                tcs_pkg::CFG_DRAIN_SECOND:  cfg_next.drain_second_ms = cfg.data;
                tcs_pkg::CFG_DRAIN_FIRST:   cfg_next.drain_first_ms  = cfg.data;
                tcs_pkg::CFG_FILL_THIRD:    cfg_next.fill_third_ms   = cfg.data;
                tcs_pkg::CFG_SETTLE:        cfg_next.settle_ms       = cfg.data;
                tcs_pkg::CFG_COLLECT:       cfg_next.collect_ms      = cfg.data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tcs_kh_calc.sv]
// KH computation and plausibility checks for the measure phase.
`default_nettype none

module tcs_kh_calc (
    input  wire logic [tcs_pkg::PH_W-1:0] ref_ph,
    input  wire logic [tcs_pkg::PH_W-1:0] sample_ph,
    output tcs_pkg::kh_res_t              kh_res
);

    logic signed [tcs_pkg::PH_W:0] delta;
    logic signed [17:0]            delta_x;
    logic signed [17:0]            prod;
    logic [tcs_pkg::PH_W-1:0]      mag;
    logic                          no_reading;

    always_comb
    begin
        delta      = $signed({1'b0, ref_ph}) - $signed({1'b0, sample_ph});
        delta_x    = {{(18 - tcs_pkg::PH_W - 1){delta[tcs_pkg::PH_W]}}, delta};
        prod       = delta_x * tcs_pkg::KH_SCALE;
        mag        = delta[tcs_pkg::PH_W] ? tcs_pkg::PH_W'(-delta)
                                          : tcs_pkg::PH_W'(delta);
        no_reading = (ref_ph == '0) || (sample_ph == '0);

        // A missing reading gives zero KH, which always fails the range check.
        if (no_reading)
        begin
            kh_res.kh  = '0;
            kh_res.err = tcs_pkg::ERR_KH_RANGE;
            kh_res.ok  = 1'b0;
        end
        else
        begin
            if (prod < tcs_pkg::KH_MIN)
            begin
                kh_res.kh = tcs_pkg::PH_W'(tcs_pkg::KH_MIN);
            end
            else if (prod > tcs_pkg::KH_MAX)
            begin
                kh_res.kh = tcs_pkg::PH_W'(tcs_pkg::KH_MAX);
            end
            else
            begin
                kh_res.kh = prod[tcs_pkg::PH_W-1:0];
            end

            if ((mag < tcs_pkg::DELTA_MIN) || (mag > tcs_pkg::DELTA_MAX))
            begin
                kh_res.err = tcs_pkg::ERR_PH_DELTA;
                kh_res.ok  = 1'b0;
            end
            else
            begin
                kh_res.err = tcs_pkg::ERR_NONE;
                kh_res.ok  = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tcs_seq.sv]
// Phase state machine and latched measurement registers of the sequencer.
`default_nettype none

module tcs_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  tcs_pkg::req_t      req,
    input  tcs_pkg::cfg_t      cfg,
    output tcs_pkg::res_t      res
);

    tcs_pkg::phase_t phase_reg, phase_next;
    tcs_pkg::sub_t   sub_reg, sub_next;
    logic            started_reg, started_next;

    logic [tcs_pkg::TIME_W-1:0]        start_time_reg, start_time_next;
    logic [tcs_pkg::PH_W-1:0]          ref_ph_reg, ref_ph_next;
    logic [tcs_pkg::PH_W-1:0]          sample_ph_reg, sample_ph_next;
    logic signed [tcs_pkg::TEMP_W-1:0] temp_reg, temp_next;
    logic [tcs_pkg::PH_W-1:0]          kh_reg, kh_next;
    logic                              valid_flag_reg, valid_flag_next;
    logic [tcs_pkg::ERR_W-1:0]         err_reg, err_next;
    logic [1:0]                        pump_a_reg, pump_a_next;
    logic                              pump_b_reg, pump_b_next;
    logic [1:0]                        pump_c_reg, pump_c_next;
    logic                              adv_reg, adv_next;

    logic [tcs_pkg::TIME_W-1:0] elapsed;
    logic                       fault;
    logic                       done;
    tcs_pkg::seq_act_t          act;
    tcs_pkg::kh_res_t           kh_res;

    tcs_kh_calc u_kh_calc (
        .ref_ph    (ref_ph_reg),
        .sample_ph (req.ph_reading),
        .kh_res    (kh_res)
    );

    assign elapsed = req.now_ms - start_time_reg;

    // Next phase, sub-step and step flag, plus the actions of this request.
    always_comb
    begin
        phase_next   = phase_reg;
        sub_next     = sub_reg;
        started_next = started_reg;
        act          = '0;
        fault        = 1'b0;
        done         = 1'b0;

        if (fire)
        begin
            case (req.req_type)
                tcs_pkg::REQ_START:
                begin
                    if (!cfg.reference_set)
                    begin
                        fault       = 1'b1;
                        act.err_val = tcs_pkg::ERR_UNCONFIGURED;
                    end
                    else if (phase_reg != tcs_pkg::PH_IDLE)
                    begin
                        act.err_wr  = 1'b1;
                        act.err_val = tcs_pkg::ERR_BUSY;
                    end
                    else
                    begin
                        phase_next   = tcs_pkg::PH_DRAIN;
                        sub_next     = tcs_pkg::SUB_IDLE;
                        started_next = 1'b0;
                        act.adv      = 1'b1;
                    end
                end
                tcs_pkg::REQ_POLL:
                begin
                    case (phase_reg)
                        tcs_pkg::PH_DRAIN:
                        begin
                            case (sub_reg)
                                tcs_pkg::SUB_IDLE:
                                begin
                                    sub_next     = tcs_pkg::SUB_ONE;
                                    started_next = 1'b0;
                                end
                                tcs_pkg::SUB_ONE:
                                begin
                                    act.pb_wr  = 1'b1;
                                    act.pb_val = tcs_pkg::PUMP_B_OFF;
                                    if (req.first_full)
                                    begin
                                        fault       = 1'b1;
                                        act.err_val = started_reg ? tcs_pkg::ERR_DRAIN_RUN
                                                                  : tcs_pkg::ERR_DRAIN_START;
                                    end
                                    else if (!started_reg)
                                    begin
                                        act.pb_val   = tcs_pkg::PUMP_B_XFER;
                                        act.time_wr  = 1'b1;
                                        started_next = 1'b1;
                                    end
                                    else if (elapsed >= cfg.drain_second_ms)
                                    begin
                                        sub_next     = tcs_pkg::SUB_TWO;
                                        started_next = 1'b0;
                                    end
                                    else
                                    begin
                                        act.pb_wr = 1'b0;
                                    end
                                end
                                tcs_pkg::SUB_TWO:
                                begin
                                    if (!started_reg)
                                    begin
                                        act.pa_wr    = 1'b1;
                                        act.pa_val   = tcs_pkg::PUMP_A_DRAIN;
                                        act.time_wr  = 1'b1;
                                        started_next = 1'b1;
                                    end
                                    else if (elapsed >= cfg.drain_first_ms)
                                    begin
                                        act.pa_wr    = 1'b1;
                                        act.pa_val   = tcs_pkg::PUMP_A_OFF;
                                        act.pb_wr    = 1'b1;
                                        act.pb_val   = tcs_pkg::PUMP_B_OFF;
                                        sub_next     = tcs_pkg::SUB_IDLE;
                                        started_next = 1'b0;
                                        done         = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    sub_next = tcs_pkg::SUB_IDLE;
                                end
                            endcase
                        end
                        tcs_pkg::PH_REF_FILL:
                        begin
                            case (sub_reg)
                                tcs_pkg::SUB_IDLE:
                                begin
                                    sub_next     = tcs_pkg::SUB_ONE;
                                    started_next = 1'b0;
                                end
                                tcs_pkg::SUB_ONE:
                                begin
                                    act.pc_wr = 1'b1;
                                    if (req.third_full)
                                    begin
                                        act.pc_val  = tcs_pkg::PUMP_C_OFF;
                                        fault       = 1'b1;
                                        act.err_val = tcs_pkg::ERR_FILL_START;
                                    end
                                    else
                                    begin
                                        act.pc_val   = tcs_pkg::PUMP_C_FILL;
                                        act.time_wr  = 1'b1;
                                        started_next = 1'b1;
                                        sub_next     = tcs_pkg::SUB_TWO;
                                    end
                                end
                                tcs_pkg::SUB_TWO:
                                begin
                                    if (req.third_full)
                                    begin
                                        act.pc_wr   = 1'b1;
                                        act.pc_val  = tcs_pkg::PUMP_C_OFF;
                                        fault       = 1'b1;
                                        act.err_val = tcs_pkg::ERR_FILL_RUN;
                                    end
                                    else if (elapsed >= cfg.fill_third_ms)
                                    begin
                                        act.pc_wr   = 1'b1;
                                        act.pc_val  = tcs_pkg::PUMP_C_OFF;
                                        act.time_wr = 1'b1;
                                        sub_next    = tcs_pkg::SUB_THREE;
                                    end
                                end
                                tcs_pkg::SUB_THREE:
                                begin
                                    // Settling time is counted from the end of the fill.
                                    if (elapsed >= cfg.settle_ms)
                                    begin
                                        act.ref_wr   = 1'b1;
                                        act.pc_wr    = 1'b1;
                                        act.pc_val   = tcs_pkg::PUMP_C_OFF;
                                        sub_next     = tcs_pkg::SUB_IDLE;
                                        started_next = 1'b0;
                                        done         = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    sub_next = tcs_pkg::SUB_IDLE;
                                end
                            endcase
                        end
                        tcs_pkg::PH_COLLECT:
                        begin
                            case (sub_reg)
                                tcs_pkg::SUB_IDLE:
                                begin
                                    sub_next     = tcs_pkg::SUB_ONE;
                                    started_next = 1'b0;
                                end
                                tcs_pkg::SUB_ONE:
                                begin
                                    act.pa_wr = 1'b1;
                                    if (req.first_full)
                                    begin
                                        act.pa_val  = tcs_pkg::PUMP_A_OFF;
                                        fault       = 1'b1;
                                        act.err_val = tcs_pkg::ERR_COLLECT_START;
                                    end
                                    else
                                    begin
                                        act.pa_val   = tcs_pkg::PUMP_A_FILL;
                                        act.time_wr  = 1'b1;
                                        started_next = 1'b1;
                                        sub_next     = tcs_pkg::SUB_TWO;
                                    end
                                end
                                tcs_pkg::SUB_TWO:
                                begin
                                    if (req.first_full)
                                    begin
                                        act.pa_wr   = 1'b1;
                                        act.pa_val  = tcs_pkg::PUMP_A_OFF;
                                        fault       = 1'b1;
                                        act.err_val = tcs_pkg::ERR_COLLECT_RUN;
                                    end
                                    else if (elapsed >= cfg.collect_ms)
                                    begin
                                        act.pa_wr    = 1'b1;
                                        act.pa_val   = tcs_pkg::PUMP_A_OFF;
                                        sub_next     = tcs_pkg::SUB_IDLE;
                                        started_next = 1'b0;
                                        done         = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    sub_next = tcs_pkg::SUB_IDLE;
                                end
                            endcase
                        end
                        tcs_pkg::PH_MEASURE:
                        begin
                            act.meas_wr = 1'b1;
                            done        = 1'b1;
                        end
                        tcs_pkg::PH_EMPTY:
                        begin
                            // Third, second move on only if the next has room; full first drains.
                            act.pc_wr  = req.third_full && !req.second_full;
                            act.pc_val = tcs_pkg::PUMP_C_XFER;
                            act.pb_wr  = req.second_full && !req.first_full;
                            act.pb_val = tcs_pkg::PUMP_B_XFER;
                            act.pa_wr  = req.first_full;
                            act.pa_val = tcs_pkg::PUMP_A_DRAIN;
                            done       = 1'b1;
                        end
                        tcs_pkg::PH_COMPLETE:
                        begin
                            phase_next = tcs_pkg::PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase

                    if (done)
                    begin
                        phase_next = tcs_pkg::phase_t'(phase_reg + 3'd1);
                        act.adv    = 1'b1;
                    end
                end
                tcs_pkg::REQ_STOP:
                begin
                    phase_next      = tcs_pkg::PH_IDLE;
                    sub_next        = tcs_pkg::SUB_IDLE;
                    started_next    = 1'b0;
                    act.pumps_clear = 1'b1;
                end
                default:
                begin
                    phase_next    = tcs_pkg::PH_IDLE;
                    sub_next      = tcs_pkg::SUB_IDLE;
                    started_next  = 1'b0;
                    act.res_clear = 1'b1;
                end
            endcase

            if (fault)
            begin
                phase_next   = tcs_pkg::PH_ERROR;
                sub_next     = tcs_pkg::SUB_IDLE;
                started_next = 1'b0;
                act.err_wr   = 1'b1;
            end
        end
    end

    // Pump commands, time stamp and latched results from the chosen actions.
    always_comb
    begin
        pump_a_next     = act.pumps_clear ? tcs_pkg::PUMP_A_OFF
                        : (act.pa_wr ? act.pa_val : pump_a_reg);
        pump_b_next     = act.pumps_clear ? tcs_pkg::PUMP_B_OFF
                        : (act.pb_wr ? act.pb_val : pump_b_reg);
        pump_c_next     = act.pumps_clear ? tcs_pkg::PUMP_C_OFF
                        : (act.pc_wr ? act.pc_val : pump_c_reg);
        start_time_next = act.time_wr ? req.now_ms : start_time_reg;
        adv_next        = fire ? act.adv : adv_reg;

        ref_ph_next     = ref_ph_reg;
        sample_ph_next  = sample_ph_reg;
        temp_next       = temp_reg;
        kh_next         = kh_reg;
        valid_flag_next = valid_flag_reg;
        err_next        = act.err_wr ? act.err_val : err_reg;

        if (act.res_clear)
        begin
            ref_ph_next     = '0;
            sample_ph_next  = '0;
            temp_next       = '0;
            kh_next         = '0;
            valid_flag_next = 1'b0;
            err_next        = tcs_pkg::ERR_NONE;
        end
        else if (act.meas_wr)
        begin
            sample_ph_next  = req.ph_reading;
            temp_next       = req.temp_reading;
            kh_next         = kh_res.kh;
            valid_flag_next = kh_res.ok;
            err_next        = kh_res.err;
        end
        else if (act.ref_wr)
        begin
            ref_ph_next = req.ph_reading;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tcs_pkg::PH_IDLE;
            sub_reg     <= tcs_pkg::SUB_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            sub_reg     <= sub_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            ref_ph_reg     <= '0;
            sample_ph_reg  <= '0;
            temp_reg       <= '0;
            kh_reg         <= '0;
            valid_flag_reg <= 1'b0;
            err_reg        <= tcs_pkg::ERR_NONE;
            pump_a_reg     <= tcs_pkg::PUMP_A_OFF;
            pump_b_reg     <= tcs_pkg::PUMP_B_OFF;
            pump_c_reg     <= tcs_pkg::PUMP_C_OFF;
            adv_reg        <= 1'b0;
        end
        else
        begin
            start_time_reg <= start_time_next;
            ref_ph_reg     <= ref_ph_next;
            sample_ph_reg  <= sample_ph_next;
            temp_reg       <= temp_next;
            kh_reg         <= kh_next;
            valid_flag_reg <= valid_flag_next;
            err_reg        <= err_next;
            pump_a_reg     <= pump_a_next;
            pump_b_reg     <= pump_b_next;
            pump_c_reg     <= pump_c_next;
            adv_reg        <= adv_next;
        end
    end

    always_comb
    begin
        res.cycle_state     = phase_reg;
        res.advanced        = adv_reg;
        res.error_code      = err_reg;
        res.pump_first_cmd  = pump_a_reg;
        res.pump_second_cmd = pump_b_reg;
        res.pump_third_cmd  = pump_c_reg;
        res.kh_centi        = kh_reg;
        res.result_valid    = valid_flag_reg;
        res.ph_ref_out      = ref_ph_reg;
        res.ph_sample_out   = sample_ph_reg;
        res.temp_out        = temp_reg;
    end

endmodule

`default_nettype wire

[hw/rtl/titration_cycle_sequencer_unit.sv]
// Top level of the titration cycle sequencer: request stage, sequencer, result port.
//
// The req channel carries one request item: start, poll, stop or clear, with a
// millisecond time stamp, the three reservoir full flags and the pH and
// temperature readings. Every request item produces exactly one result item on
// the res channel: the cycle state, an advance flag, the last error code, the
// three pump commands and the latched measurement (KH, pH values, temperature).
// The cfg channel writes the enable bit and the five phase durations; it is
// always ready and should only be used while no request is in flight.
//
// A request item is captured in an input register and processed once the
// result slot is free, and its result item is registered by the sequencer. The
// state update is a single pass of phase logic with one 32-bit elapsed-time
// subtract and compare and one small constant multiply, so a new request item
// can be accepted every cycle while res.ready stays high. The sequencer state
// registers double as the result register: while the receiver stalls, the held
// request waits in the input register and req.ready stays high only while that
// register is free. Reset clears the cycle to idle, all pumps off, all latched
// values and the configuration to zero, with no result pending.
`default_nettype none

`include "titration_cycle_sequencer_unit_macros.svh"

module titration_cycle_sequencer_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    tcs_req_if.sink   req,
    tcs_res_if.source res,
    tcs_cfg_if.sink   cfg
);

    tcs_pkg::req_t req_q_reg;
    tcs_pkg::req_t req_q_next;
    logic          in_valid_reg, in_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic          req_acc;
    logic          fire;
    tcs_pkg::cfg_t cfg_q;
    tcs_pkg::res_t res_q;

    // The held request is processed when the result slot is empty or being drained.
    assign fire      = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || fire;
    assign req_acc   = req.valid && req.ready;

    always_comb
    begin
        req_q_next = req_q_reg;
        if (req_acc)
        begin
            req_q_next.req_type     = tcs_pkg::req_type_t'(req.req_type);
            req_q_next.now_ms       = req.now_ms;
            req_q_next.first_full   = req.first_full;
            req_q_next.second_full  = req.second_full;
            req_q_next.third_full   = req.third_full;
            req_q_next.ph_reading   = req.ph_reading;
            req_q_next.temp_reading = req.temp_reading;
        end

        if (req_acc)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request payload needs no reset: it is only read while in_valid_reg is set.
    always_ff @(posedge clk)
    begin
        req_q_reg <= req_q_next;
    end

    tcs_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    tcs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req_q_reg),
        .cfg   (cfg_q),
        .res   (res_q)
    );

    assign res.valid           = out_valid_reg;
    assign res.cycle_state     = res_q.cycle_state;
    assign res.advanced        = res_q.advanced;
    assign res.error_code      = res_q.error_code;
    assign res.pump_first_cmd  = res_q.pump_first_cmd;
    assign res.pump_second_cmd = res_q.pump_second_cmd;
    assign res.pump_third_cmd  = res_q.pump_third_cmd;
    assign res.kh_centi        = res_q.kh_centi;
    assign res.result_valid    = res_q.result_valid;
    assign res.ph_ref_out      = res_q.ph_ref_out;
    assign res.ph_sample_out   = res_q.ph_sample_out;
    assign res.temp_out        = res_q.temp_out;

    // A processed request always leaves a result item on the port.
    `TCS_ASSERT_NEXT(a_fire_gives_result, fire, res.valid)

    // A stop request leaves the cycle idle with every pump off.
    `TCS_ASSERT_NEXT(a_stop_idles, fire && (req_q_reg.req_type == tcs_pkg::REQ_STOP),
        (res.cycle_state == tcs_pkg::PH_IDLE) && (res.pump_first_cmd == tcs_pkg::PUMP_A_OFF)
        && (res.pump_second_cmd == tcs_pkg::PUMP_B_OFF)
        && (res.pump_third_cmd == tcs_pkg::PUMP_C_OFF))

    // A valid measurement always carries a KH inside the clamp range.
    `TCS_ASSERT_NOW(a_valid_kh_range, res.result_valid,
        (res.kh_centi >= 11'd100) && (res.kh_centi <= 11'd2000))

    // An advance always lands in a running phase or in complete.
    `TCS_ASSERT_NOW(a_advance_phase, res.valid && res.advanced,
        (res.cycle_state != tcs_pkg::PH_IDLE) && (res.cycle_state != tcs_pkg::PH_ERROR))

endmodule

`default_nettype wire
